// ----- sv/kfcv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kfcv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // configuration register indexes
  localparam int CFG_DT  = 0;
  localparam int CFG_RP  = 1;
  localparam int CFG_RV  = 2;
  localparam int CFG_ICP = 3;
  localparam int CFG_ICV = 4;
  localparam int CFG_NUM = 5;

  localparam logic [CFG_NUM-1:0][31:0] CFG_RST = {
    32'd655360, 32'd1310720, 32'd32768, 32'd655360, 32'd2184
  };

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_LOAD,
    CS_FETCH,
    CS_ISSUE,
    CS_WAIT,
    CS_RDOUT,
    CS_DONE
  } core_st_e;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_SUMF,
    AS_MUL0,
    AS_MUL1,
    AS_MULF,
    AS_DIV,
    AS_DIVF
  } alu_st_e;

  // register file map; axis registers of the y axis sit AXIS_STRIDE higher
  localparam logic [4:0] R_DT   = 5'd0;
  localparam logic [4:0] R_RP   = 5'd1;
  localparam logic [4:0] R_RV   = 5'd2;
  localparam logic [4:0] R_P    = 5'd3;
  localparam logic [4:0] R_V    = 5'd4;
  localparam logic [4:0] R_A    = 5'd5;
  localparam logic [4:0] R_B    = 5'd6;
  localparam logic [4:0] R_C    = 5'd7;
  localparam logic [4:0] R_MP   = 5'd8;
  localparam logic [4:0] R_MV   = 5'd9;
  localparam logic [4:0] AXIS_STRIDE = 5'd7;
  localparam logic [4:0] LOAD_LAST   = 5'd16;
  localparam logic [4:0] T_P1   = 5'd17;
  localparam logic [4:0] T_B1   = 5'd18;
  localparam logic [4:0] T_A1   = 5'd19;
  localparam logic [4:0] T_S1   = 5'd20;
  localparam logic [4:0] T_S2   = 5'd21;
  localparam logic [4:0] T_Q    = 5'd22;
  localparam logic [4:0] T_D    = 5'd23;
  localparam logic [4:0] T_K11  = 5'd24;
  localparam logic [4:0] T_K12  = 5'd25;
  localparam logic [4:0] T_K21  = 5'd26;
  localparam logic [4:0] T_K22  = 5'd27;
  localparam logic [4:0] T_E1   = 5'd28;
  localparam logic [4:0] T_E2   = 5'd29;
  localparam logic [4:0] T_X    = 5'd30;

  localparam logic [5:0] STEP_LAST = 6'd35;

  typedef struct packed {
    op_e        op;
    logic [4:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
  } uop_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic start;
    logic res_take;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

  function automatic uop_t mk(input op_e o, input logic [4:0] d, input logic [4:0] a,
                              input logic [4:0] b);
    uop_t u;
    u.op  = o;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    return u;
  endfunction

  // one axis of predict, gain and update
  function automatic uop_t uop(input logic [5:0] step);
    uop_t u;
    u = mk(OP_ADD, T_X, T_X, T_X);
    case (step)
      6'd0:  u = mk(OP_MUL, T_X,   R_DT,  R_V);
      6'd1:  u = mk(OP_ADD, T_P1,  R_P,   T_X);
      6'd2:  u = mk(OP_MUL, T_X,   R_DT,  R_C);
      6'd3:  u = mk(OP_ADD, T_B1,  R_B,   T_X);
      6'd4:  u = mk(OP_MUL, T_X,   R_DT,  R_B);
      6'd5:  u = mk(OP_ADD, T_A1,  R_A,   T_X);
      6'd6:  u = mk(OP_MUL, T_X,   R_DT,  T_B1);
      6'd7:  u = mk(OP_ADD, T_A1,  T_A1,  T_X);
      6'd8:  u = mk(OP_ADD, T_S1,  T_A1,  R_RP);
      6'd9:  u = mk(OP_ADD, T_S2,  R_C,   R_RV);
      6'd10: u = mk(OP_MUL, T_Q,   T_B1,  T_B1);
      6'd11: u = mk(OP_MUL, T_X,   T_S1,  T_S2);
      6'd12: u = mk(OP_SUB, T_D,   T_X,   T_Q);
      6'd13: u = mk(OP_MUL, T_X,   T_A1,  T_S2);
      6'd14: u = mk(OP_SUB, T_X,   T_X,   T_Q);
      6'd15: u = mk(OP_DIV, T_K11, T_X,   T_D);
      6'd16: u = mk(OP_MUL, T_X,   T_B1,  R_RP);
      6'd17: u = mk(OP_DIV, T_K12, T_X,   T_D);
      6'd18: u = mk(OP_MUL, T_X,   T_B1,  R_RV);
      6'd19: u = mk(OP_DIV, T_K21, T_X,   T_D);
      6'd20: u = mk(OP_MUL, T_X,   R_C,   T_S1);
      6'd21: u = mk(OP_SUB, T_X,   T_X,   T_Q);
      6'd22: u = mk(OP_DIV, T_K22, T_X,   T_D);
      6'd23: u = mk(OP_SUB, T_E1,  R_MP,  T_P1);
      6'd24: u = mk(OP_SUB, T_E2,  R_MV,  R_V);
      6'd25: u = mk(OP_MUL, T_X,   T_K11, T_E1);
      6'd26: u = mk(OP_MUL, T_S1,  T_K12, T_E2);
      6'd27: u = mk(OP_ADD, T_X,   T_X,   T_S1);
      6'd28: u = mk(OP_ADD, R_P,   T_P1,  T_X);
      6'd29: u = mk(OP_MUL, T_X,   T_K21, T_E1);
      6'd30: u = mk(OP_MUL, T_S1,  T_K22, T_E2);
      6'd31: u = mk(OP_ADD, T_X,   T_X,   T_S1);
      6'd32: u = mk(OP_ADD, R_V,   R_V,   T_X);
      6'd33: u = mk(OP_MUL, R_A,   R_RP,  T_K11);
      6'd34: u = mk(OP_MUL, R_B,   R_RP,  T_K21);
      6'd35: u = mk(OP_MUL, R_C,   R_RV,  T_K22);
      default: u = mk(OP_ADD, T_X, T_X, T_X);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- sv/kalman_filter_const_velocity_2d_unit.sv -----
// Constant-velocity Kalman filter for two axes (x/vx and y/vy).
// Input stream: s_axis_tdata carries meas_x, meas_y, meas_vx, meas_vy
// (signed Q16.16, lowest bits first); s_axis_tuser is first_of_batch,
// which loads position from the measurement, zeroes velocity and restores
// the initial covariance before filtering.
// Output stream: m_axis_tdata carries est_x, est_y, est_vx, est_vy.
// Configuration: APB registers at 0x00 time_step, 0x04 meas_noise_pos,
// 0x08 meas_noise_vel, 0x0C init_cov_pos, 0x10 init_cov_vel.
// Sequence: a load of the register file, 72 microcode operations on one shared
// add/multiply/divide unit, then a readout of the estimate; the serial
// divider dominates the run time.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a result until taken; the next request runs
// meanwhile and waits at its end while m_axis_tready stays low.
// After reset, a request without first_of_batch starts from a zero estimate
// and from the reset values of the init registers as covariance.
`timescale 1ns / 1ps
`default_nettype none

module kalman_filter_const_velocity_2d_unit #(
  parameter int FRAC_BITS = kfcv_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = kfcv_pkg::WORD_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // meas_x, meas_y, meas_vx, meas_vy
  input  wire          s_axis_tuser,   // first_of_batch
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [127:0] m_axis_tdata,   // est_x, est_y, est_vx, est_vy
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import kfcv_pkg::*;

  logic [CFG_NUM-1:0][31:0] cfg_q;
  logic [2:0]               widx;
  logic [3:0][31:0]         meas_q;
  logic                     first_q;
  logic [3:0][31:0]         est;
  logic                     m_valid_q;
  logic [127:0]             m_data_q;

  core_ctl_t  ctl;
  core_stat_t stat;
  alu_req_t   alu_req;
  logic signed [WORD_BITS-1:0] alu_a, alu_b, alu_res;
  logic       alu_done;

  assign pready = 1'b1;
  assign widx   = paddr[4:2];

  always_comb begin
    prdata = '0;
    if (widx < 3'(CFG_NUM)) prdata = cfg_q[widx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (psel && penable && pwrite && pready && widx < 3'(CFG_NUM)) begin
      cfg_q[widx] <= pwdata;
    end
  end

  assign s_axis_tready = stat.idle;
  assign ctl.start     = s_axis_tvalid && s_axis_tready;
  assign ctl.res_take  = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (ctl.start) begin
      meas_q  <= s_axis_tdata;
      first_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (stat.res_valid && ctl.res_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid && ctl.res_take) m_data_q <= est;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  kfcv_core #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .first_i    (first_q),
    .meas_i     (meas_q),
    .cfg_i      (cfg_q),
    .est_o      (est),
    .alu_req_o  (alu_req),
    .alu_a_o    (alu_a),
    .alu_b_o    (alu_b),
    .alu_res_i  (alu_res),
    .alu_done_i (alu_done)
  );

  kfcv_alu #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .done_o (alu_done)
  );

endmodule

`default_nettype wire

// ----- sv/kfcv_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kfcv_alu #(
  parameter int FRAC_BITS = kfcv_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = kfcv_pkg::WORD_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  kfcv_pkg::alu_req_t            req_i,
  input  wire logic signed [WORD_BITS-1:0] a_i,
  input  wire logic signed [WORD_BITS-1:0] b_i,
  output logic signed [WORD_BITS-1:0]   res_o,
  output logic                          done_o
);
  import kfcv_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int H  = (W + 1) / 2;
  localparam int QW = W + F;
  localparam int CW = $clog2(QW);
  localparam logic signed [W:0] SMAX = $signed({2'b00, {(W-1){1'b1}}});
  localparam logic signed [W:0] SMIN = $signed({2'b11, {(W-1){1'b0}}});

  alu_st_e state_q, state_d;
  op_e     op_q;
  logic signed [W-1:0] a_q, b_q;
  logic [W-1:0]        ma_q, mb_q;
  logic                neg_q;
  logic [2*W-1:0]      acc_q;
  logic [W-1:0]        rem_q;
  logic [QW-1:0]       num_q, quo_q;
  logic [CW-1:0]       cnt_q;

  logic [W-1:0]     mag_a, mag_b, lim;
  logic [H-1:0]     mpart;
  logic [W+H-1:0]   prod;
  logic [W:0]       trial;
  logic             ge;
  logic signed [W:0] sum;
  logic [2*W:0]     rnd;
  logic [W-1:0]     mres;
  logic [W-1:0]     qres;

  assign mag_a = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  assign lim   = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign mpart = (state_q == AS_MUL0) ? mb_q[H-1:0] : H'(mb_q[W-1:H]);
  assign prod  = (W+H)'(ma_q) * (W+H)'(mpart);
  assign trial = {rem_q, num_q[QW-1]};
  assign ge    = trial >= {1'b0, mb_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_ADD, OP_SUB: state_d = AS_SUMF;
            OP_MUL:         state_d = AS_MUL0;
            OP_DIV:         state_d = AS_DIV;
          endcase
        end
      end
      AS_MUL0: state_d = AS_MUL1;
      AS_MUL1: state_d = AS_MULF;
      AS_DIV:  if (cnt_q == '0) state_d = AS_DIVF;
      AS_SUMF, AS_MULF, AS_DIVF: state_d = AS_IDLE;
      default: state_d = AS_IDLE;
    endcase
  end

  always_comb begin
    sum  = (op_q == OP_SUB) ? ((W+1)'(a_q) - (W+1)'(b_q)) : ((W+1)'(a_q) + (W+1)'(b_q));
    rnd  = ((2*W+1)'(acc_q) + ((2*W+1)'(1) << (F - 1))) >> F;
    mres = (rnd > (2*W+1)'(lim)) ? lim : rnd[W-1:0];
    qres = (quo_q > QW'(lim)) ? lim : quo_q[W-1:0];
    done_o = 1'b0;
    res_o  = '0;
    unique case (state_q)
      AS_SUMF: begin
        done_o = 1'b1;
        if (sum > SMAX) res_o = SMAX[W-1:0];
        else if (sum < SMIN) res_o = SMIN[W-1:0];
        else res_o = sum[W-1:0];
      end
      AS_MULF: begin
        done_o = 1'b1;
        res_o  = neg_q ? (~mres + W'(1)) : mres;
      end
      AS_DIVF: begin
        done_o = 1'b1;
        // a zero divisor gives zero gain
        if (mb_q == '0) res_o = '0;
        else res_o = neg_q ? (~qres + W'(1)) : qres;
      end
      default: begin
        done_o = 1'b0;
        res_o  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == AS_IDLE && req_i.start) begin
      op_q  <= req_i.op;
      a_q   <= a_i;
      b_q   <= b_i;
      ma_q  <= mag_a;
      mb_q  <= mag_b;
      neg_q <= a_i[W-1] ^ b_i[W-1];
      num_q <= {mag_a, {F{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= CW'(QW - 1);
    end else begin
      if (state_q == AS_MUL0) acc_q <= (2*W)'(prod);
      if (state_q == AS_MUL1) acc_q <= acc_q + ((2*W)'(prod) << H);
      if (state_q == AS_DIV) begin
        rem_q <= ge ? W'(trial - {1'b0, mb_q}) : W'(trial);
        quo_q <= {quo_q[QW-2:0], ge};
        num_q <= num_q << 1;
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/kfcv_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kfcv_core #(
  parameter int FRAC_BITS = kfcv_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = kfcv_pkg::WORD_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  kfcv_pkg::core_ctl_t               ctl_i,
  output kfcv_pkg::core_stat_t              stat_o,
  input  wire                               first_i,
  input  wire logic [3:0][31:0]             meas_i,
  input  wire logic [kfcv_pkg::CFG_NUM-1:0][31:0] cfg_i,
  output logic [3:0][31:0]                  est_o,
  output kfcv_pkg::alu_req_t                alu_req_o,
  output logic signed [WORD_BITS-1:0]       alu_a_o,
  output logic signed [WORD_BITS-1:0]       alu_b_o,
  input  wire logic signed [WORD_BITS-1:0]  alu_res_i,
  input  wire                               alu_done_i
);
  import kfcv_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int TW  = WORD_BITS + 42;
  localparam int UPI = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DNI = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int UPO = DNI;
  localparam int DNO = UPI;
  localparam logic signed [TW-1:0] WMAX = TW'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] WMIN = -WMAX - TW'(64'sd1);
  localparam logic signed [TW-1:0] OMAX = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] OMIN = -OMAX - TW'(64'sd1);

  // rescale with rounding half away from zero; to_word and from_word then clamp
  function automatic logic signed [TW-1:0] rescale(input logic signed [TW-1:0] v,
                                                   input int up, input int dn);
    logic signed [TW-1:0] t;
    logic [TW-1:0]        m;
    t = v <<< up;
    m = t[TW-1] ? (~t + TW'(1)) : t;
    m = (m + TW'((64'd1 << dn) >> 1)) >> dn;
    return t[TW-1] ? $signed(~m + TW'(1)) : $signed(m);
  endfunction

  function automatic logic signed [W-1:0] to_word(input logic signed [32:0] v);
    logic signed [TW-1:0] r;
    r = rescale(TW'(v), UPI, DNI);
    if (r > WMAX) r = WMAX;
    else if (r < WMIN) r = WMIN;
    return r[W-1:0];
  endfunction

  function automatic logic [31:0] from_word(input logic signed [W-1:0] v);
    logic signed [TW-1:0] r;
    r = rescale(TW'(v), UPO, DNO);
    if (r > OMAX) r = OMAX;
    else if (r < OMIN) r = OMIN;
    return r[31:0];
  endfunction

  function automatic logic [4:0] amap(input logic [4:0] a, input logic ax);
    return (ax && a >= R_P && a <= R_MV) ? a + AXIS_STRIDE : a;
  endfunction

  core_st_e state_q, state_d;
  logic [4:0] cnt_q;
  logic [5:0] step_q;
  logic       axis_q;
  logic       fresh_q;

  logic signed [W-1:0] rf [32];
  logic signed [W-1:0] rda_q, rdb_q;
  logic [4:0]          ra, rb, wa;
  logic signed [W-1:0] wd;
  logic                we;

  uop_t       u;
  logic       ld_ax;
  logic [4:0] ld_k;
  logic       keep_n;
  logic [31:0] cov_p, cov_v;
  logic signed [W-1:0] ld_val;
  logic       ld_we;

  assign u = uop(step_q);

  // load values for the register file, one entry per cycle
  always_comb begin
    ld_ax  = cnt_q >= (R_MV + 5'd1);
    ld_k   = ld_ax ? cnt_q - AXIS_STRIDE : cnt_q;
    keep_n = first_i || fresh_q;
    cov_p  = (fresh_q && !first_i) ? CFG_RST[CFG_ICP] : cfg_i[CFG_ICP];
    cov_v  = (fresh_q && !first_i) ? CFG_RST[CFG_ICV] : cfg_i[CFG_ICV];
    ld_val = '0;
    ld_we  = 1'b0;
    unique case (ld_k)
      R_DT: begin ld_val = to_word({1'b0, cfg_i[CFG_DT]}); ld_we = 1'b1; end
      R_RP: begin ld_val = to_word({1'b0, cfg_i[CFG_RP]}); ld_we = 1'b1; end
      R_RV: begin ld_val = to_word({1'b0, cfg_i[CFG_RV]}); ld_we = 1'b1; end
      R_P: begin
        ld_val = first_i ? to_word({meas_i[ld_ax][31], meas_i[ld_ax]}) : '0;
        ld_we  = keep_n;
      end
      R_V: begin ld_val = '0; ld_we = keep_n; end
      R_A: begin ld_val = to_word({1'b0, cov_p}); ld_we = keep_n; end
      R_B: begin ld_val = '0; ld_we = keep_n; end
      R_C: begin ld_val = to_word({1'b0, cov_v}); ld_we = keep_n; end
      R_MP: begin
        ld_val = to_word({meas_i[ld_ax][31], meas_i[ld_ax]});
        ld_we  = 1'b1;
      end
      R_MV: begin
        ld_val = to_word({meas_i[{1'b1, ld_ax}][31], meas_i[{1'b1, ld_ax}]});
        ld_we  = 1'b1;
      end
      default: begin ld_val = '0; ld_we = 1'b0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:  if (ctl_i.start) state_d = CS_LOAD;
      CS_LOAD:  if (cnt_q == LOAD_LAST) state_d = CS_FETCH;
      CS_FETCH: state_d = CS_ISSUE;
      CS_ISSUE: state_d = CS_WAIT;
      CS_WAIT: begin
        if (alu_done_i) begin
          state_d = (step_q == STEP_LAST && axis_q) ? CS_RDOUT : CS_FETCH;
        end
      end
      CS_RDOUT: if (cnt_q == 5'd4) state_d = CS_DONE;
      CS_DONE:  if (ctl_i.res_take) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    ra = '0;
    rb = '0;
    we = 1'b0;
    wa = '0;
    wd = '0;
    alu_req_o.start = 1'b0;
    alu_req_o.op    = u.op;
    stat_o.idle      = (state_q == CS_IDLE);
    stat_o.res_valid = (state_q == CS_DONE);
    unique case (state_q)
      CS_LOAD: begin
        we = ld_we;
        wa = cnt_q;
        wd = ld_val;
      end
      CS_FETCH: begin
        ra = amap(u.sa, axis_q);
        rb = amap(u.sb, axis_q);
      end
      CS_ISSUE: alu_req_o.start = 1'b1;
      CS_WAIT: begin
        we = alu_done_i;
        wa = amap(u.dst, axis_q);
        wd = alu_res_i;
      end
      CS_RDOUT: begin
        // estimate order x, y, vx, vy
        ra = amap(cnt_q[1] ? R_V : R_P, cnt_q[0]);
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  assign alu_a_o = rda_q;
  assign alu_b_o = rdb_q;

  always_ff @(posedge clk_i) begin
    if (we) rf[wa] <= wd;
    rda_q <= rf[ra];
    rdb_q <= rf[rb];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CS_RDOUT && cnt_q != '0) begin
      est_o[2'(cnt_q - 5'd1)] <= from_word(rda_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      axis_q  <= 1'b0;
      fresh_q <= 1'b1;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        CS_IDLE: begin
          cnt_q  <= '0;
          step_q <= '0;
          axis_q <= 1'b0;
        end
        CS_LOAD: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == LOAD_LAST) fresh_q <= 1'b0;
        end
        CS_WAIT: begin
          if (alu_done_i) begin
            cnt_q <= '0;
            if (step_q == STEP_LAST) begin
              step_q <= '0;
              axis_q <= 1'b1;
            end else begin
              step_q <= step_q + 6'd1;
            end
          end
        end
        CS_RDOUT: cnt_q <= cnt_q + 5'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_IDLE) |-> !alu_done_i) else $error("alu done while core idle");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST) else $error("microcode step out of range");
  a_fresh_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_LOAD && cnt_q == LOAD_LAST) |=> !fresh_q)
    else $error("reset state not retired after load");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == CS_IDLE) else $error("start while busy");

endmodule

`default_nettype wire
